/* hdl/cmr_pkg.sv */
package cmr_pkg;

    localparam int unsigned BYTE_W    = 8;
    localparam int unsigned POS_W     = 6;
    localparam int unsigned LEN_W     = 16;
    localparam int unsigned CHAN_W    = 32;
    localparam int unsigned CMD_W     = 7;
    localparam int unsigned SEQ_W     = 8;
    localparam int unsigned KIND_W    = 2;

    // init report marker in the header byte
    localparam int unsigned INIT_FLAG_BIT = 7;

    localparam logic [LEN_W-1:0] MAX_LEN_RESET = 16'd7609;

    localparam logic [KIND_W-1:0] KIND_PAYLOAD = 2'd0;
    localparam logic [KIND_W-1:0] KIND_EMPTY   = 2'd1;
    localparam logic [KIND_W-1:0] KIND_ERROR   = 2'd2;

    localparam logic ERR_LENGTH   = 1'b0;
    localparam logic ERR_SEQUENCE = 1'b1;

    localparam logic [POS_W-1:0] POS_CHAN_FIRST = 6'd0;
    localparam logic [POS_W-1:0] POS_HEADER     = 6'd4;
    localparam logic [POS_W-1:0] POS_LEN_HI     = 6'd5;
    localparam logic [POS_W-1:0] POS_LEN_LO     = 6'd6;

    typedef enum logic [2:0] {
        CLS_CHAN_FIRST,
        CLS_CHAN,
        CLS_HEADER,
        CLS_LEN_HI,
        CLS_LEN_LO,
        CLS_BODY
    } pos_class_t;

    typedef struct packed {
        pos_class_t          cls;
        logic [BYTE_W-1:0]   data;
    } cmr_item_t;

    typedef struct packed {
        logic [KIND_W-1:0]   kind;
        logic [BYTE_W-1:0]   payload_byte;
        logic [LEN_W-1:0]    payload_offset;
        logic                message_done;
        logic [CHAN_W-1:0]   channel_id;
        logic [CMD_W-1:0]    command_code;
        logic [LEN_W-1:0]    message_length;
        logic                error_code;
    } cmr_result_t;

endpackage

/* hdl/cmr_if.sv */
interface cmr_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] report_byte;
    logic [5:0] byte_position;

    modport source (output valid, output report_byte, output byte_position, input ready);
    modport sink   (input valid, input report_byte, input byte_position, output ready);
endinterface

interface cmr_out_if;
    logic        valid;
    logic        ready;
    logic [1:0]  kind;
    logic [7:0]  payload_byte;
    logic [15:0] payload_offset;
    logic        message_done;
    logic [31:0] channel_id;
    logic [6:0]  command_code;
    logic [15:0] message_length;
    logic        error_code;

    modport source (
        output valid, output kind, output payload_byte, output payload_offset,
        output message_done, output channel_id, output command_code,
        output message_length, output error_code, input ready
    );
    modport sink (
        input valid, input kind, input payload_byte, input payload_offset,
        input message_done, input channel_id, input command_code,
        input message_length, input error_code, output ready
    );
endinterface

/* hdl/cmr_front.sv */
module cmr_front
    import cmr_pkg::*;
#(
    parameter int unsigned REPORT_BYTES = 64
) (
    cmr_in_if.sink          in_ch,
    input  logic            q_full,
    output logic            q_push,
    output cmr_item_t       q_item
);

    localparam logic [POS_W:0] REPORT_END = (POS_W+1)'(REPORT_BYTES);

    logic beat;
    logic beyond;

    assign in_ch.ready = !q_full;
    assign beat        = in_ch.valid && !q_full;
    // positions past the report end are consumed and dropped here
    assign beyond      = {1'b0, in_ch.byte_position} >= REPORT_END;
    assign q_push      = beat && !beyond;

    always_comb
    begin
        q_item.data = in_ch.report_byte;
        unique case (in_ch.byte_position)
            POS_CHAN_FIRST: q_item.cls = CLS_CHAN_FIRST;
            6'd1, 6'd2, 6'd3: q_item.cls = CLS_CHAN;
            POS_HEADER:     q_item.cls = CLS_HEADER;
            POS_LEN_HI:     q_item.cls = CLS_LEN_HI;
            POS_LEN_LO:     q_item.cls = CLS_LEN_LO;
            default:        q_item.cls = CLS_BODY;
        endcase
    end

endmodule

/* hdl/cmr_queue.sv */
module cmr_queue
    import cmr_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        push,
    input  cmr_item_t   push_item,
    input  logic        pop,
    output logic        full,
    output logic        head_valid,
    output cmr_item_t   head_item
);

    cmr_item_t  mem [2];
    logic       wr_ptr_reg;
    logic       rd_ptr_reg;
    logic [1:0] count_reg;

    assign full       = count_reg == 2'd2;
    assign head_valid = count_reg != 2'd0;
    assign head_item  = mem[rd_ptr_reg];

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem[wr_ptr_reg] <= push_item;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end
        else
        begin
            if (push)
            begin
                wr_ptr_reg <= !wr_ptr_reg;
            end
            if (pop)
            begin
                rd_ptr_reg <= !rd_ptr_reg;
            end
            if (push && !pop)
            begin
                count_reg <= count_reg + 2'd1;
            end
            else if (pop && !push)
            begin
                count_reg <= count_reg - 2'd1;
            end
        end
    end

endmodule

/* hdl/cmr_back.sv */
module cmr_back
    import cmr_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              cfg_write_en,
    input  logic [LEN_W-1:0]  cfg_write_data,
    input  logic              head_valid,
    input  cmr_item_t         head_item,
    output logic              pop,
    cmr_out_if.source         out_ch
);

    typedef enum logic [1:0] {
        MODE_HEADER,
        MODE_LENGTH,
        MODE_PAYLOAD,
        MODE_IGNORE
    } mode_t;

    logic [LEN_W-1:0]  max_len_reg;
    logic [CHAN_W-1:0] chan_stage_reg,  chan_stage_next;
    logic [CHAN_W-1:0] msg_chan_reg,    msg_chan_next;
    logic [CMD_W-1:0]  msg_cmd_reg,     msg_cmd_next;
    logic [LEN_W-1:0]  exp_len_reg,     exp_len_next;
    logic [LEN_W-1:0]  rcv_cnt_reg,     rcv_cnt_next;
    logic [SEQ_W-1:0]  next_seq_reg,    next_seq_next;
    logic              active_reg,      active_next;
    mode_t             mode_reg,        mode_next;
    logic [BYTE_W-1:0] len_hi_reg,      len_hi_next;
    cmr_result_t       out_reg,         out_next;
    logic              out_valid_reg;
    logic              emit;

    logic [LEN_W-1:0]  new_len;
    logic [LEN_W-1:0]  rcv_inc;
    logic [BYTE_W-1:0] b;

    assign pop     = head_valid && (!out_valid_reg || out_ch.ready);
    assign b       = head_item.data;
    assign new_len = {len_hi_reg, b};
    assign rcv_inc = rcv_cnt_reg + LEN_W'(1);

    always_comb
    begin
        chan_stage_next = chan_stage_reg;
        msg_chan_next   = msg_chan_reg;
        msg_cmd_next    = msg_cmd_reg;
        exp_len_next    = exp_len_reg;
        rcv_cnt_next    = rcv_cnt_reg;
        next_seq_next   = next_seq_reg;
        active_next     = active_reg;
        mode_next       = mode_reg;
        len_hi_next     = len_hi_reg;
        out_next        = '0;
        emit            = 1'b0;

        if (pop)
        begin
            unique case (head_item.cls)
                CLS_CHAN_FIRST:
                begin
                    chan_stage_next = {{(CHAN_W-BYTE_W){1'b0}}, b};
                    mode_next       = MODE_HEADER;
                end
                CLS_CHAN:
                begin
                    chan_stage_next = {chan_stage_reg[CHAN_W-BYTE_W-1:0], b};
                end
                CLS_HEADER:
                begin
                    if (b[INIT_FLAG_BIT])
                    begin
                        active_next   = 1'b0;
                        msg_chan_next = chan_stage_reg;
                        msg_cmd_next  = b[CMD_W-1:0];
                        mode_next     = MODE_LENGTH;
                    end
                    else if (!active_reg || chan_stage_reg != msg_chan_reg
                             || b != next_seq_reg)
                    begin
                        active_next         = 1'b0;
                        mode_next           = MODE_IGNORE;
                        emit                = 1'b1;
                        out_next.kind       = KIND_ERROR;
                        out_next.channel_id = chan_stage_reg;
                        out_next.error_code = ERR_SEQUENCE;
                    end
                    else
                    begin
                        next_seq_next = next_seq_reg + SEQ_W'(1);
                        mode_next     = MODE_PAYLOAD;
                    end
                end
                default:
                begin
                    if (mode_reg == MODE_LENGTH)
                    begin
                        if (head_item.cls == CLS_LEN_HI)
                        begin
                            len_hi_next = b;
                        end
                        else if (head_item.cls == CLS_LEN_LO)
                        begin
                            exp_len_next = new_len;
                            if (new_len > max_len_reg)
                            begin
                                active_next             = 1'b0;
                                mode_next               = MODE_IGNORE;
                                emit                    = 1'b1;
                                out_next.kind           = KIND_ERROR;
                                out_next.channel_id     = msg_chan_reg;
                                out_next.message_length = new_len;
                                out_next.error_code     = ERR_LENGTH;
                            end
                            else
                            begin
                                rcv_cnt_next  = '0;
                                next_seq_next = '0;
                                if (new_len == '0)
                                begin
                                    active_next           = 1'b0;
                                    mode_next             = MODE_IGNORE;
                                    emit                  = 1'b1;
                                    out_next.kind         = KIND_EMPTY;
                                    out_next.message_done = 1'b1;
                                    out_next.channel_id   = msg_chan_reg;
                                    out_next.command_code = msg_cmd_reg;
                                end
                                else
                                begin
                                    active_next = 1'b1;
                                    mode_next   = MODE_PAYLOAD;
                                end
                            end
                        end
                    end
                    else if (mode_reg == MODE_PAYLOAD)
                    begin
                        if (rcv_cnt_reg >= exp_len_reg)
                        begin
                            mode_next = MODE_IGNORE;
                        end
                        else
                        begin
                            rcv_cnt_next            = rcv_inc;
                            emit                    = 1'b1;
                            out_next.kind           = KIND_PAYLOAD;
                            out_next.payload_byte   = b;
                            out_next.payload_offset = rcv_cnt_reg;
                            if (rcv_inc == exp_len_reg)
                            begin
                                active_next             = 1'b0;
                                mode_next               = MODE_IGNORE;
                                out_next.message_done   = 1'b1;
                                out_next.channel_id     = msg_chan_reg;
                                out_next.command_code   = msg_cmd_reg;
                                out_next.message_length = exp_len_reg;
                            end
                        end
                    end
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            max_len_reg    <= MAX_LEN_RESET;
            chan_stage_reg <= '0;
            msg_chan_reg   <= '0;
            msg_cmd_reg    <= '0;
            exp_len_reg    <= '0;
            rcv_cnt_reg    <= '0;
            next_seq_reg   <= '0;
            active_reg     <= 1'b0;
            mode_reg       <= MODE_HEADER;
            len_hi_reg     <= '0;
            out_reg        <= '0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            if (cfg_write_en)
            begin
                max_len_reg <= cfg_write_data;
            end
            chan_stage_reg <= chan_stage_next;
            msg_chan_reg   <= msg_chan_next;
            msg_cmd_reg    <= msg_cmd_next;
            exp_len_reg    <= exp_len_next;
            rcv_cnt_reg    <= rcv_cnt_next;
            next_seq_reg   <= next_seq_next;
            active_reg     <= active_next;
            mode_reg       <= mode_next;
            len_hi_reg     <= len_hi_next;
            if (emit)
            begin
                out_reg       <= out_next;
                out_valid_reg <= 1'b1;
            end
            else if (out_ch.ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    assign out_ch.valid          = out_valid_reg;
    assign out_ch.kind           = out_reg.kind;
    assign out_ch.payload_byte   = out_reg.payload_byte;
    assign out_ch.payload_offset = out_reg.payload_offset;
    assign out_ch.message_done   = out_reg.message_done;
    assign out_ch.channel_id     = out_reg.channel_id;
    assign out_ch.command_code   = out_reg.command_code;
    assign out_ch.message_length = out_reg.message_length;
    assign out_ch.error_code     = out_reg.error_code;

endmodule

/* hdl/ctaphid_message_reassembler.sv */
// path: an accepted beat is written into the queue, and its result into the result register
// throughput: one report byte per cycle while the result sink is ready, set by the back end update
// a two-entry queue parts classification from message state, and a result register
// parts the back end from the result sink
// reset: asynchronous active-low rst_n clears all message state, max length to 7609
module ctaphid_message_reassembler
    import cmr_pkg::*;
#(
    parameter int unsigned REPORT_BYTES = 64
) (
    input  logic              clk,
    input  logic              rst_n,
    cmr_in_if.sink            in_ch,
    cmr_out_if.source         out_ch,
    input  logic              cfg_write_en,
    input  logic [LEN_W-1:0]  cfg_write_data
);

    // front to queue
    logic      q_push;
    cmr_item_t q_item;
    logic      q_full;

    // queue to back end
    logic      head_valid;
    cmr_item_t head_item;
    logic      q_pop;

    // front end: takes every beat, drops bytes past the report end and tags the
    // rest by position class
    cmr_front #(
        .REPORT_BYTES (REPORT_BYTES)
    ) u_front (
        .in_ch  (in_ch),
        .q_full (q_full),
        .q_push (q_push),
        .q_item (q_item)
    );

    // short queue takes up to two input bytes while the result sink stalls, then holds the input off
    cmr_queue u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (q_push),
        .push_item  (q_item),
        .pop        (q_pop),
        .full       (q_full),
        .head_valid (head_valid),
        .head_item  (head_item)
    );

    // back end: header decode, length check, sequence check, payload offsets
    cmr_back u_back (
        .clk            (clk),
        .rst_n          (rst_n),
        .cfg_write_en   (cfg_write_en),
        .cfg_write_data (cfg_write_data),
        .head_valid     (head_valid),
        .head_item      (head_item),
        .pop            (q_pop),
        .out_ch         (out_ch)
    );

endmodule

/* verif/tb_ctaphid_message_reassembler.sv */
module tb_ctaphid_message_reassembler
    import cmr_pkg::*;
();

    timeunit 1ns;
    timeprecision 1ps;

    localparam int unsigned REPORT_BYTES   = 64;
    localparam int unsigned CLK_PERIOD     = 20;
    localparam int unsigned RESET_CYCLES   = 3;
    // covers the result register plus the two-entry queue, with margin
    localparam int unsigned DRAIN_CYCLES   = 8;
    localparam int unsigned HOLD_CYCLES    = 300;
    localparam int unsigned TIMEOUT_CYCLES = 500_000;
    localparam int unsigned PRINT_CAP      = 40;
    localparam int unsigned PHASE_BEATS    = 250;

    // ways a generated message can be broken on purpose
    localparam int FAULT_NONE = 0;
    localparam int FAULT_SEQ  = 1;
    localparam int FAULT_CHAN = 2;
    localparam int FAULT_CUT  = 3;

    typedef enum logic [1:0] {
        RM_HEADER,
        RM_LENGTH,
        RM_PAYLOAD,
        RM_SKIP
    } report_mode_t;

    typedef struct packed {
        logic [POS_W-1:0]  pos;
        logic [BYTE_W-1:0] data;
    } report_beat_t;

    logic              clk = 1'b0;
    logic              rst_n = 1'b0;
    logic              cfg_write_en = 1'b0;
    logic [LEN_W-1:0]  cfg_write_data = '0;

    cmr_in_if  in_ch ();
    cmr_out_if out_ch ();

    ctaphid_message_reassembler #(
        .REPORT_BYTES (REPORT_BYTES)
    ) DUT (
        .clk            (clk),
        .rst_n          (rst_n),
        .in_ch          (in_ch),
        .out_ch         (out_ch),
        .cfg_write_en   (cfg_write_en),
        .cfg_write_data (cfg_write_data)
    );

    always #(CLK_PERIOD / 2) clk = ~clk;

    // beats waiting to be offered, and results the reassembly predicts
    report_beat_t beat_q[$];
    cmr_result_t  expected_results[$];

    int unsigned beats_queued = 0;
    int unsigned beats_taken = 0;
    int unsigned useful_beats = 0;
    int unsigned mismatch_count = 0;

    // idling knobs; the percentages and hold_request change on the falling edge, hold_off on the rising edge
    int unsigned send_idle_pct = 0;
    int unsigned sink_stall_pct = 0;
    logic        hold_request = 1'b0;
    logic        hold_off = 1'b0;

    // predicted reassembly state, mirrors what the block must hold
    logic [CHAN_W-1:0] chan_shift = '0;
    logic [CHAN_W-1:0] msg_chan = '0;
    logic [CMD_W-1:0]  msg_cmd = '0;
    logic [LEN_W-1:0]  msg_len = '0;
    logic [LEN_W-1:0]  got_count = '0;
    logic [SEQ_W-1:0]  seq_next = '0;
    logic              msg_open = 1'b0;
    report_mode_t      rpt_mode = RM_HEADER;
    logic [BYTE_W-1:0] len_hi = '0;
    logic [LEN_W-1:0]  max_len = MAX_LEN_RESET;

    // known levels from time zero
    initial
    begin
        in_ch.valid = 1'b0;
        in_ch.report_byte = '0;
        in_ch.byte_position = '0;
        out_ch.ready = 1'b0;
    end

    task automatic note_mismatch(input string msg);
        mismatch_count++;
        if (mismatch_count <= PRINT_CAP)
            $display("mismatch at %0t ns: %s", $time, msg);
    endtask

    // walk one accepted report byte through the reassembly and queue its result, if any
    task automatic predict_reassembly(input logic [BYTE_W-1:0] b, input logic [POS_W-1:0] pos);
        cmr_result_t r;
        logic [LEN_W-1:0] off;
        r = '0;
        if (pos >= REPORT_BYTES)
        begin
            // outside the report, nothing happens
        end
        else if (pos < POS_HEADER)
        begin
            // channel id, big-endian; the first byte opens a new report
            if (pos == POS_CHAN_FIRST)
            begin
                chan_shift = {24'd0, b};
                rpt_mode = RM_HEADER;
            end
            else
                chan_shift = {chan_shift[CHAN_W-9:0], b};
        end
        else if (pos == POS_HEADER)
        begin
            // header byte is decoded whatever the mode
            if (b[INIT_FLAG_BIT])
            begin
                msg_open = 1'b0;
                msg_chan = chan_shift;
                msg_cmd = b[CMD_W-1:0];
                rpt_mode = RM_LENGTH;
            end
            else if (!msg_open || chan_shift != msg_chan || b != seq_next)
            begin
                // continuation that does not fit the open message
                msg_open = 1'b0;
                rpt_mode = RM_SKIP;
                r.kind = KIND_ERROR;
                r.channel_id = chan_shift;
                r.error_code = ERR_SEQUENCE;
                expected_results.push_back(r);
            end
            else
            begin
                seq_next = seq_next + 1'b1;
                rpt_mode = RM_PAYLOAD;
            end
        end
        else if (rpt_mode == RM_LENGTH)
        begin
            if (pos == POS_LEN_HI)
                len_hi = b;
            else if (pos == POS_LEN_LO)
            begin
                // a missing high byte leaves the stale one in place
                msg_len = {len_hi, b};
                if (msg_len > max_len)
                begin
                    msg_open = 1'b0;
                    rpt_mode = RM_SKIP;
                    r.kind = KIND_ERROR;
                    r.channel_id = msg_chan;
                    r.message_length = msg_len;
                    r.error_code = ERR_LENGTH;
                    expected_results.push_back(r);
                end
                else
                begin
                    got_count = '0;
                    seq_next = '0;
                    if (msg_len == '0)
                    begin
                        msg_open = 1'b0;
                        rpt_mode = RM_SKIP;
                        r.kind = KIND_EMPTY;
                        r.message_done = 1'b1;
                        r.channel_id = msg_chan;
                        r.command_code = msg_cmd;
                        expected_results.push_back(r);
                    end
                    else
                    begin
                        msg_open = 1'b1;
                        rpt_mode = RM_PAYLOAD;
                    end
                end
            end
        end
        else if (rpt_mode == RM_PAYLOAD)
        begin
            if (got_count >= msg_len)
                rpt_mode = RM_SKIP;
            else
            begin
                off = got_count;
                got_count = got_count + 1'b1;
                r.kind = KIND_PAYLOAD;
                r.payload_byte = b;
                r.payload_offset = off;
                // last payload byte carries the whole message header
                if (got_count == msg_len)
                begin
                    msg_open = 1'b0;
                    rpt_mode = RM_SKIP;
                    r.message_done = 1'b1;
                    r.channel_id = msg_chan;
                    r.command_code = msg_cmd;
                    r.message_length = msg_len;
                end
                expected_results.push_back(r);
            end
        end
    endtask

    // beat driver: offers the next queued beat, idling at random
    always @(posedge clk)
    begin : beat_driver
        report_beat_t nxt;
        if (!rst_n)
            in_ch.valid <= 1'b0;
        else if (!in_ch.valid || in_ch.ready)
        begin
            if (beat_q.size() != 0 && $urandom_range(99) >= send_idle_pct)
            begin
                nxt = beat_q.pop_front();
                in_ch.valid <= 1'b1;
                in_ch.report_byte <= nxt.data;
                in_ch.byte_position <= nxt.pos;
            end
            else
                in_ch.valid <= 1'b0;
        end
    end

    // result sink: random stalls, plus the long hold-off when asked
    always @(posedge clk)
    begin : sink_ready
        if (!rst_n)
            out_ch.ready <= 1'b0;
        else
            out_ch.ready <= !hold_off && ($urandom_range(99) >= sink_stall_pct);
    end

    // long sink hold-off, counted here, while the sender keeps offering beats
    initial
    begin : sink_hold
        wait (hold_request);
        @(posedge clk);
        hold_off <= 1'b1;
        repeat (HOLD_CYCLES) @(posedge clk);
        hold_off <= 1'b0;
    end

    // monitor: predicts on each accepted input beat, checks each accepted result beat
    always @(posedge clk)
    begin : result_monitor
        cmr_result_t want;
        if (rst_n)
        begin
            if (in_ch.valid && in_ch.ready)
            begin
                predict_reassembly(in_ch.report_byte, in_ch.byte_position);
                beats_taken++;
            end
            if (out_ch.valid && out_ch.ready)
            begin
                if (expected_results.size() == 0)
                    note_mismatch("result beat with nothing expected");
                else
                begin
                    want = expected_results.pop_front();
                    if (out_ch.kind !== want.kind)
                        note_mismatch($sformatf("kind %0d, want %0d", out_ch.kind, want.kind));
                    if (out_ch.payload_byte !== want.payload_byte)
                        note_mismatch($sformatf("payload_byte %0h, want %0h",
                                                out_ch.payload_byte, want.payload_byte));
                    if (out_ch.payload_offset !== want.payload_offset)
                        note_mismatch($sformatf("payload_offset %0d, want %0d",
                                                out_ch.payload_offset, want.payload_offset));
                    if (out_ch.message_done !== want.message_done)
                        note_mismatch($sformatf("message_done %0b, want %0b",
                                                out_ch.message_done, want.message_done));
                    if (out_ch.channel_id !== want.channel_id)
                        note_mismatch($sformatf("channel_id %0h, want %0h",
                                                out_ch.channel_id, want.channel_id));
                    if (out_ch.command_code !== want.command_code)
                        note_mismatch($sformatf("command_code %0h, want %0h",
                                                out_ch.command_code, want.command_code));
                    if (out_ch.message_length !== want.message_length)
                        note_mismatch($sformatf("message_length %0d, want %0d",
                                                out_ch.message_length, want.message_length));
                    if (out_ch.error_code !== want.error_code)
                        note_mismatch($sformatf("error_code %0b, want %0b",
                                                out_ch.error_code, want.error_code));
                end
            end
        end
    end

    // padding beats do not count as useful stimulus
    task automatic push_beat(input int pos, input int data, input bit counts);
        report_beat_t beat;
        beat.pos = POS_W'(pos);
        beat.data = BYTE_W'(data);
        beat_q.push_back(beat);
        beats_queued++;
        if (counts)
            useful_beats++;
    endtask

    // channel in bytes 0..3, body from the header byte on, random padding to rlen
    task automatic push_report(input logic [CHAN_W-1:0] chan, input logic [BYTE_W-1:0] body[$],
                               input int rlen);
        for (int p = 0; p < rlen; p++)
        begin
            if (p < POS_HEADER)
                push_beat(p, chan[CHAN_W-1-8*p -: 8], 1'b1);
            else if (p - POS_HEADER < body.size())
                push_beat(p, body[p-POS_HEADER], 1'b1);
            else
                push_beat(p, $urandom_range(255), 1'b0);
        end
    endtask

    function automatic logic [CHAN_W-1:0] pick_channel();
        case ($urandom_range(3))
            0: return 32'hFFFF_FFFF;
            1: return 32'h0000_0000;
            default: return $urandom;
        endcase
    endfunction

    // mostly short reports to keep padding down, full size now and then
    function automatic int pick_rlen();
        int r;
        r = $urandom_range(99);
        if (r < 50)
            return $urandom_range(8, 16);
        if (r < 80)
            return $urandom_range(17, 40);
        return REPORT_BYTES;
    endfunction

    function automatic int pick_len();
        int r;
        r = $urandom_range(99);
        if (r < 10)
            return 0;
        if (r < 72)
            return $urandom_range(1, 40);
        if (r < 84)
            return $urandom_range(41, 200);
        // right at the limit and one past it, where the limit is small
        if (r < 92 && max_len <= 16'd300)
            return int'(max_len) + $urandom_range(1);
        return $urandom_range(201, 65535);
    endfunction

    // one message: init report, then continuations with running sequence numbers
    task automatic send_message(input logic [CHAN_W-1:0] chan, input logic [CMD_W-1:0] cmd,
                                input int len, input int rlen, input int fault);
        logic [BYTE_W-1:0] body[$];
        int sent;
        int seq;
        int cut;
        body.delete();
        body.push_back({1'b1, cmd});
        body.push_back(BYTE_W'(len >> 8));
        body.push_back(BYTE_W'(len));
        sent = 0;
        while (sent < len && body.size() < rlen - POS_HEADER)
        begin
            body.push_back(BYTE_W'($urandom));
            sent++;
        end
        push_report(chan, body, rlen);
        // rejected length: the rest of the message would only draw errors
        if (len > max_len)
            return;
        // long messages are cut short to bound the run
        if (len > 300 && fault == FAULT_NONE)
            fault = FAULT_CUT;
        cut = $urandom_range(3);
        seq = 0;
        while (sent < len)
        begin
            rlen = pick_rlen();
            body.delete();
            body.push_back(BYTE_W'(seq));
            if (seq == cut && fault != FAULT_NONE)
            begin
                if (fault == FAULT_CUT)
                    return;
                if (fault == FAULT_SEQ)
                    body[0] = BYTE_W'((seq + $urandom_range(1, 127)) % 128);
                else
                    chan = chan ^ (32'd1 << $urandom_range(31));
                push_report(chan, body, rlen);
                return;
            end
            while (sent < len && body.size() < rlen - POS_HEADER)
            begin
                body.push_back(BYTE_W'($urandom));
                sent++;
            end
            push_report(chan, body, rlen);
            seq++;
        end
    endtask

    // mostly well-formed messages, some broken ones, stray continuations and noise
    task automatic random_phase(input int unsigned target);
        logic [BYTE_W-1:0] body[$];
        int unsigned start;
        int r;
        start = useful_beats;
        while (useful_beats - start < target)
        begin
            r = $urandom_range(99);
            if (r < 68)
                send_message(pick_channel(), CMD_W'($urandom), pick_len(), pick_rlen(),
                             FAULT_NONE);
            else if (r < 84)
                send_message(pick_channel(), CMD_W'($urandom), $urandom_range(1, 120),
                             pick_rlen(), $urandom_range(FAULT_SEQ, FAULT_CUT));
            else if (r < 92)
            begin
                // continuation with no matching message behind it, most of the time
                body.delete();
                body.push_back(BYTE_W'($urandom_range(127)));
                push_report(pick_channel(), body, pick_rlen());
            end
            else
            begin
                repeat ($urandom_range(1, 8))
                    push_beat($urandom_range(63), $urandom_range(255), 1'b1);
            end
        end
    endtask

    // everything offered taken and every predicted result seen, then let the block settle
    task automatic drain();
        wait (beats_taken == beats_queued && expected_results.size() == 0);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    // only while the block is idle
    task automatic set_max_length(input logic [LEN_W-1:0] value);
        @(posedge clk);
        cfg_write_en <= 1'b1;
        cfg_write_data <= value;
        @(posedge clk);
        cfg_write_en <= 1'b0;
        max_len = value;
        @(negedge clk);
    endtask

    initial
    begin : stimulus
        logic [BYTE_W-1:0] body[$];
        logic [CHAN_W-1:0] wrap_chan;

        repeat (RESET_CYCLES) @(posedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // directed: empty message on the all-ones channel, top command value
        body.delete();
        body.push_back(8'hFF);
        body.push_back(8'h00);
        body.push_back(8'h00);
        push_report(32'hFFFF_FFFF, body, 7);

        // init with the high length byte missing, so the stale high byte applies;
        // then a second header byte mid-report continues the same message
        for (int p = 0; p < POS_HEADER; p++)
            push_beat(p, 0, 1'b1);
        push_beat(POS_HEADER, {1'b1, 7'd0}, 1'b1);
        push_beat(POS_LEN_LO, 8'h02, 1'b1);
        push_beat(POS_LEN_LO + 1, 8'hFF, 1'b1);
        push_beat(POS_HEADER, 8'h00, 1'b1);
        push_beat(POS_LEN_HI, 8'h00, 1'b1);

        // largest length, over the reset limit, then a continuation with no message open
        body.delete();
        body.push_back({1'b1, 7'h05});
        body.push_back(8'hFF);
        body.push_back(8'hFF);
        push_report(32'hA55A_0FF0, body, 7);
        push_beat(POS_HEADER, 8'h00, 1'b1);
        drain();
        @(negedge clk);

        // flat out at the reset limit, with the long sink hold-off to back up the input
        send_idle_pct = 0;
        sink_stall_pct = 0;
        hold_request = 1'b1;

        // sequence counter walks past 127, where no continuation header can match
        wrap_chan = $urandom;
        body.delete();
        body.push_back({1'b1, 7'h01});
        body.push_back(8'h00);
        body.push_back(8'd200);
        body.push_back(BYTE_W'($urandom));
        push_report(wrap_chan, body, 8);
        for (int s = 0; s < 128; s++)
        begin
            body.delete();
            body.push_back(BYTE_W'(s));
            push_report(wrap_chan, body, POS_HEADER + 1);
        end
        body.delete();
        body.push_back(8'h00);
        push_report(wrap_chan, body, POS_HEADER + 1);
        random_phase(PHASE_BEATS);
        drain();

        // nothing but empty messages accepted, sender idling
        set_max_length(16'h0000);
        send_idle_pct = 47;
        sink_stall_pct = 0;
        random_phase(PHASE_BEATS);
        drain();

        // every length accepted, sink stalling
        set_max_length(16'hFFFF);
        send_idle_pct = 0;
        sink_stall_pct = 47;
        random_phase(PHASE_BEATS);
        drain();

        // small limit so lengths land on both sides of it, both sides idling
        set_max_length(LEN_W'($urandom_range(16, 200)));
        send_idle_pct = 33;
        sink_stall_pct = 33;
        random_phase(PHASE_BEATS);
        drain();

        if (expected_results.size() != 0)
            note_mismatch("expected results left over");
        if (mismatch_count == 0)
            $display("*** PASSED ***");
        else
            $display("*** FAILED ***");
        $finish;
    end

    initial
    begin : watchdog
        #(TIMEOUT_CYCLES * CLK_PERIOD);
        $display("*** FAILED ***");
        $finish;
    end

endmodule

/* ctaphid_message_reassembler.f */
hdl/cmr_pkg.sv
hdl/cmr_if.sv
hdl/cmr_front.sv
hdl/cmr_queue.sv
hdl/cmr_back.sv
hdl/ctaphid_message_reassembler.sv
verif/tb_ctaphid_message_reassembler.sv
